[sv/mbps_pkg.sv]
// Shared types and constants of the masked byte pattern scanner.
`timescale 1ns / 1ps
`default_nettype none

package mbps_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int ADDR_WIDTH_DEF  = 48;

    // Pattern registers hold at most this many bytes
    localparam int PATTERN_BYTES = 16;
    localparam int LEN_W         = 5;
    localparam int RESULT_W      = 48;
    localparam int BASE_W        = 48;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 3;
    localparam int QUEUE_DEPTH   = 2;

    // Branch decode: B/BL opcode byte and its 24-bit immediate
    localparam int          IMM_W          = 24;
    localparam int          DELTA_W        = IMM_W + 3;
    localparam logic [7:0]  BRANCH_OP      = 8'hEA;
    localparam logic [7:0]  BRANCH_OP_MASK = 8'hFE;
    localparam int          BRANCH_MIN_LEN = 4;
    localparam int          PC_AHEAD       = 8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CARE_MASK    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LEN  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_XREF_MODE    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_REGION_BASE  = 3'd5;

    typedef struct packed {
        logic [8*PATTERN_BYTES-1:0] pattern;
        logic [PATTERN_BYTES-1:0]   care;
        logic [LEN_W-1:0]           length;
        logic                       xref;
    } mbps_match_cfg_t;

    // Classification of one item that produces a result
    typedef struct packed {
        logic        found;
        logic        branch_ok;
        logic [31:0] word;
    } mbps_cls_t;

endpackage

`default_nettype wire

[sv/mbps_front.sv]
// Front end: byte window, position count and pattern match classification.
`timescale 1ns / 1ps
`default_nettype none

module mbps_front #(
    parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF,
    parameter int ADDR_WIDTH  = mbps_pkg::ADDR_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [7:0]                  data_byte,
    input  logic                        last_byte,
    input  mbps_pkg::mbps_match_cfg_t   mcfg,
    output logic                        push,
    output mbps_pkg::mbps_cls_t         cls,
    output logic [ADDR_WIDTH-1:0]       offset
);
    import mbps_pkg::*;

    localparam int WIN    = (PATTERN_MAX < PATTERN_BYTES) ? PATTERN_MAX : PATTERN_BYTES;
    localparam int WIN_IW = $clog2(WIN);

    logic [7:0]            win_reg  [WIN];
    logic [7:0]            win_next [WIN];
    logic [ADDR_WIDTH-1:0] pos_reg;
    logic [ADDR_WIDTH-1:0] pos_next;
    logic                  reported_reg;
    logic                  reported_next;
    logic [LEN_W-1:0]      len;
    logic [LEN_W-1:0]      tap_idx [WIN];
    logic [WIN-1:0]        byte_ok;
    logic [LEN_W-1:0]      word_idx [4];
    logic [7:0]            word_byte [4];
    logic                  match;

    // clamp length to the window depth
    always_comb
    begin
        if (mcfg.length > LEN_W'(WIN))
        begin
            len = LEN_W'(WIN);
        end
        else
        begin
            len = mcfg.length;
        end
    end

    always_comb
    begin
        win_next[0] = data_byte;
        for (int k = 1; k < WIN; k++)
        begin
            win_next[k] = win_reg[k-1];
        end
    end

    assign pos_next = (&pos_reg) ? pos_reg : pos_reg + 1'b1;

    // pattern byte i lines up with window tap len-1-i
    for (genvar i = 0; i < WIN; i++)
    begin : g_cmp
        assign tap_idx[i] = len - LEN_W'(i + 1);
        assign byte_ok[i] = (LEN_W'(i) >= len) || !mcfg.care[i] ||
                            (win_next[tap_idx[i][WIN_IW-1:0]] == mcfg.pattern[8*i +: 8]);
    end

    for (genvar j = 0; j < 4; j++)
    begin : g_word
        assign word_idx[j]  = len - LEN_W'(j + 1);
        assign word_byte[j] = win_next[word_idx[j][WIN_IW-1:0]];
    end

    assign match = (len != '0) && (pos_next >= ADDR_WIDTH'(len)) && (&byte_ok);

    assign cls.found     = match;
    assign cls.branch_ok = mcfg.xref && (len >= LEN_W'(BRANCH_MIN_LEN));
    assign cls.word      = {word_byte[3], word_byte[2], word_byte[1], word_byte[0]};
    assign offset        = pos_next - ADDR_WIDTH'(len);
    assign push          = accept && !reported_reg && (match || last_byte);

    always_comb
    begin
        reported_next = reported_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                reported_next = 1'b0;
            end
            else if (!reported_reg)
            begin
                reported_next = match;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            reported_reg <= 1'b0;
        end
        else
        begin
            reported_reg <= reported_next;
            if (accept)
            begin
                if (last_byte)
                begin
                    pos_reg <= '0;
                end
                else if (!reported_reg)
                begin
                    pos_reg <= pos_next;
                end
            end
        end
    end

    // only taps below the position count are ever compared
    always_ff @(posedge clk)
    begin
        if (accept && !reported_reg)
        begin
            for (int k = 0; k < WIN; k++)
            begin
                win_reg[k] <= win_next[k];
            end
        end
    end

endmodule

`default_nettype wire

[sv/mbps_queue.sv]
// Short FIFO between the classification front end and the address back end.
`timescale 1ns / 1ps
`default_nettype none

module mbps_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = mbps_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] head,
    output logic              empty,
    output logic              full
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign head  = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[sv/mbps_back.sv]
// Back end: match address, branch decode and the result output register.
`timescale 1ns / 1ps
`default_nettype none

module mbps_back #(
    parameter int ADDR_WIDTH = mbps_pkg::ADDR_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  mbps_pkg::mbps_cls_t           q_cls,
    input  logic [ADDR_WIDTH-1:0]         q_offset,
    input  logic [mbps_pkg::BASE_W-1:0]   region_base,
    output logic                          pop,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic                          found,
    output logic [mbps_pkg::RESULT_W-1:0] result_address,
    output logic                          was_branch
);
    import mbps_pkg::*;

    logic                  advance;
    logic                  is_branch;
    logic [DELTA_W-1:0]    delta_short;
    logic [63:0]           delta_ext;

    logic                  s1_valid_reg;
    logic                  s1_found_reg;
    logic                  s1_branch_reg;
    logic [ADDR_WIDTH-1:0] s1_addr_reg;
    logic [ADDR_WIDTH-1:0] s1_delta_reg;

    logic                  out_valid_reg;
    logic                  found_reg;
    logic                  branch_reg;
    logic [ADDR_WIDTH-1:0] addr_reg;

    // advance the whole back pipe unless a result sits stalled at the output
    assign advance = !out_valid_reg || !out_stall;
    assign pop     = advance && !q_empty;

    assign is_branch = q_cls.found && q_cls.branch_ok &&
                       ((q_cls.word[31:24] & BRANCH_OP_MASK) == BRANCH_OP);

    // imm24 * 4 + 8, sign-extended
    assign delta_short = {q_cls.word[IMM_W-1], q_cls.word[IMM_W-1:0], 2'b00} +
                         DELTA_W'(PC_AHEAD);
    assign delta_ext   = {{(64 - DELTA_W){delta_short[DELTA_W-1]}}, delta_short};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= !q_empty;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_found_reg  <= q_cls.found;
            s1_branch_reg <= is_branch;
            s1_addr_reg   <= q_cls.found ? ADDR_WIDTH'(region_base) + q_offset : '0;
            s1_delta_reg  <= ADDR_WIDTH'(delta_ext);
            found_reg     <= s1_found_reg;
            branch_reg    <= s1_branch_reg;
            addr_reg      <= s1_branch_reg ? s1_addr_reg + s1_delta_reg : s1_addr_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign was_branch     = branch_reg;
    assign result_address = RESULT_W'(addr_reg);

endmodule

`default_nettype wire

[sv/masked_byte_pattern_scanner.sv]
// Top level of the masked byte pattern scanner: registers, front end, queue, back end.
// A result passes in turn through the queue, the address stage and the output register.
// Throughput: one byte per cycle; the front end classifies each byte against the window
// combinationally, and input stalls only while the two-entry result queue is full.
// Reset (rst_n, async, active low): empties queue and back pipe, clears position count
// and match flag, loads register defaults (pattern length 1, everything else zero).
`timescale 1ns / 1ps
`default_nettype none

module masked_byte_pattern_scanner #(
    parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF,
    parameter int ADDR_WIDTH  = mbps_pkg::ADDR_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data,

    // input byte stream
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       data_byte,
    input  logic                             last_byte,

    // result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             found,
    output logic [mbps_pkg::RESULT_W-1:0]    result_address,
    output logic                             was_branch
);
    import mbps_pkg::*;

    localparam int Q_W = $bits(mbps_cls_t) + ADDR_WIDTH;

    // configuration registers
    logic [63:0]              pattern_low_reg;
    logic [63:0]              pattern_high_reg;
    logic [PATTERN_BYTES-1:0] care_mask_reg;
    logic [LEN_W-1:0]         pattern_length_reg;
    logic                     xref_mode_reg;
    logic [BASE_W-1:0]        region_base_reg;

    mbps_match_cfg_t          mcfg;
    logic                     in_accept;
    logic                     push;
    mbps_cls_t                push_cls;
    logic [ADDR_WIDTH-1:0]    push_offset;
    logic [Q_W-1:0]           q_head;
    logic                     q_empty;
    logic                     q_full;
    logic                     pop;
    mbps_cls_t                head_cls;
    logic [ADDR_WIDTH-1:0]    head_offset;

    // Register writes are always taken; indexes past the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            care_mask_reg      <= '0;
            pattern_length_reg <= LEN_W'(1);
            xref_mode_reg      <= 1'b0;
            region_base_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LOW:  pattern_low_reg    <= cfg_data;
                CFG_PATTERN_HIGH: pattern_high_reg   <= cfg_data;
                CFG_CARE_MASK:    care_mask_reg      <= cfg_data[PATTERN_BYTES-1:0];
                CFG_PATTERN_LEN:  pattern_length_reg <= cfg_data[LEN_W-1:0];
                CFG_XREF_MODE:    xref_mode_reg      <= cfg_data[0];
                CFG_REGION_BASE:  region_base_reg    <= cfg_data[BASE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign mcfg.pattern = {pattern_high_reg, pattern_low_reg};
    assign mcfg.care    = care_mask_reg;
    assign mcfg.length  = pattern_length_reg;
    assign mcfg.xref    = xref_mode_reg;

    // Hold input while the queue has no room for a possible result; bytes that
    // produce nothing are held too, which keeps the stall a plain register decode.
    assign in_stall  = q_full;
    assign in_accept = in_valid && !in_stall;

    // Front end: until the region has reported a match, shift the byte into the window and
    // advance the position; classify the item as match, region end without match, or nothing.
    mbps_front #(
        .PATTERN_MAX (PATTERN_MAX),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .mcfg      (mcfg),
        .push      (push),
        .cls       (push_cls),
        .offset    (push_offset)
    );

    // Queue decouples classification from address arithmetic and output stall.
    mbps_queue #(
        .DATA_W (Q_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_cls, push_offset}),
        .pop       (pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign head_cls    = q_head[Q_W-1:ADDR_WIDTH];
    assign head_offset = q_head[ADDR_WIDTH-1:0];

    // Back end: base + offset, then the branch target add, into the output register.
    mbps_back #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_cls          (head_cls),
        .q_offset       (head_offset),
        .region_base    (region_base_reg),
        .pop            (pop),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .found          (found),
        .result_address (result_address),
        .was_branch     (was_branch)
    );

`ifndef NO_ASSERTIONS
    // The front end never writes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("result queue overflow");

    // A not-found result carries a zero address and no branch flag.
    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (result_address == '0 && !was_branch))
        else $error("not-found result with nonzero fields");

    // A branch target is only reported for a match.
    a_branch_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && was_branch) |-> found)
        else $error("branch flag without a match");

    // Nothing is taken from an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("result queue underflow");
`endif

endmodule

`default_nettype wire
